FILE: design/ivhf_pkg.sv
package ivhf_pkg;

    localparam int unsigned MaxStates = 64;
    localparam int unsigned OneQ15    = 32768;
    localparam int unsigned HalfQ15   = 16384;

    typedef struct packed {
        logic [63:0] allowed_mask;
        logic [14:0] recomb_fraction;
        logic        first_locus;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  state_index;
        logic [15:0] probability;
        logic        last_state;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POW,
        S_ACC,
        S_SUM,
        S_DIV,
        S_EMIT
    } t_state;

    // control from the sequencer to the accumulator row
    typedef struct packed {
        logic clear;
        logic step;
        logic load_first;
        logic shift_out;
    } t_cell_ctl;

endpackage

FILE: design/ivhf_cell.sv
// one accumulator cell: owns state j, sees prev_probs streaming past
module ivhf_cell import ivhf_pkg::*; #(
    parameter int unsigned MEIOSES = 6
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [MEIOSES-1:0]   i_index,
    input  logic                 i_allowed,
    input  logic [MEIOSES-1:0]   i_q,
    input  logic [15:0]          i_prob,
    input  logic [16*(MEIOSES+1)-1:0] i_powers,
    input  logic [39:0]          i_acc_next,
    output logic [39:0]          o_acc
);

    logic [39:0]        r_acc;
    logic [MEIOSES-1:0] w_x;
    logic [3:0]         w_k;
    logic [15:0]        w_pw;
    logic [31:0]        w_prod;

    always_comb begin
        w_x = i_q ^ i_index;
        w_k = '0;
        for (int b = 0; b < MEIOSES; b++) begin
            w_k = w_k + {3'd0, w_x[b]};
        end
        w_pw = i_powers[w_k*16 +: 16];
        w_prod = i_prob * w_pw;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.load_first) begin
            r_acc <= i_allowed ? 40'(OneQ15) : '0;
        end else if (i_ctl.step) begin
            if (i_allowed) begin
                r_acc <= r_acc + {8'd0, w_prod};
            end
        end else if (i_ctl.shift_out) begin
            r_acc <= i_acc_next;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: design/ivhf_div.sv
// restoring divider, one quotient bit per cycle
module ivhf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [55:0] i_num,
    input  logic [39:0] i_den,
    output logic        o_done,
    output logic [55:0] o_quot
);

    logic [55:0] r_q;
    logic [40:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [40:0] w_try;

    assign w_try = {r_rem[39:0], r_q[55]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (w_try >= {1'b0, i_den}) begin
                    r_rem <= w_try - {1'b0, i_den};
                    r_q   <= {r_q[54:0], 1'b1};
                end else begin
                    r_rem <= w_try;
                    r_q   <= {r_q[54:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd55) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q;

endmodule

FILE: design/inheritance_vector_hmm_forward.sv
// channel | dir | handshake      | payload
// item in | in  | i_start/o_busy | i_item (t_in_item)
// result  | out | o_valid strobe | o_result (t_out_item)
// a first locus: a sum pass over the row, then for each state a divide and an emit
// any other locus first fills the power table and runs an accumulate pass
// the serial divider (56 quotient bits per state) dominates; busy rises at the accept edge
// synchronous active-low reset clears control only; prev_probs is undefined until written
// the receiver cannot stall: each result shows for one cycle
module inheritance_vector_hmm_forward import ivhf_pkg::*; #(
    parameter int unsigned MEIOSES = 6
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int unsigned NStates = 1 << MEIOSES;
    localparam int unsigned IW = MEIOSES;

    t_state r_state, n_state;
    t_cell_ctl w_ctl;

    logic [63:0]     r_mask;
    logic [63:0]     w_allow;
    logic [14:0]     r_r;
    logic [IW:0]     r_cnt;
    logic [IW-1:0]   r_qd;
    logic [15:0]     r_prev [NStates];
    logic [15:0]     r_prob_q;
    logic [15:0]     r_rp, r_sp;
    logic [15:0]     r_rpow [MEIOSES+1];
    logic [15:0]     r_spow [MEIOSES+1];
    logic [16*(MEIOSES+1)-1:0] r_pow;
    logic [3:0]      r_pk;
    logic            r_pphase;
    logic [39:0]     r_total;
    logic [39:0]     w_acc [NStates+1];
    logic [39:0]     w_num_acc;
    logic            w_div_go, w_div_done;
    logic [55:0]     w_quot;
    logic [15:0]     w_prob;
    logic [31:0]     r_m1, r_m2;

    // power table: rp and sp chains step together, then pair up
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_pk     <= '0;
            r_pphase <= 1'b0;
            r_rp     <= 16'(OneQ15);
            r_sp     <= 16'(OneQ15);
        end else if (r_state == S_POW && r_pk != 4'(MEIOSES + 1)) begin
            r_pphase <= ~r_pphase;
            if (!r_pphase) begin
                r_rpow[r_pk[2:0]] <= r_rp;
                r_spow[r_pk[2:0]] <= r_sp;
                r_m1 <= 32'(r_rp) * 32'(r_r);
                r_m2 <= 32'(r_sp) * (32'(OneQ15) - 32'(r_r));
            end else begin
                r_rp <= 16'((r_m1 + 32'(HalfQ15)) >> 15);
                r_sp <= 16'((r_m2 + 32'(HalfQ15)) >> 15);
                r_pk <= r_pk + 4'd1;
            end
        end
    end

    logic [3:0] r_tk;
    logic       r_tph;
    logic [31:0] r_tm;
    always_ff @(posedge i_clk) begin
        if (r_state != S_POW) begin
            r_tk  <= '0;
            r_tph <= 1'b0;
        end else if (r_pk == 4'(MEIOSES + 1) && r_tk != 4'(MEIOSES + 1)) begin
            r_tph <= ~r_tph;
            if (!r_tph) begin
                r_tm <= 32'(r_rpow[r_tk[2:0]]) * 32'(r_spow[3'(MEIOSES) - r_tk[2:0]]);
            end else begin
                r_pow[r_tk*16 +: 16] <= 16'((r_tm + 32'(HalfQ15)) >> 15);
                r_tk <= r_tk + 4'd1;
            end
        end
    end

    // a first locus loads the cells at the accept edge, before r_mask is written
    assign w_allow = (r_state == S_IDLE) ? i_item.allowed_mask : r_mask;

    // row of cells: prev_probs broadcast one per cycle, results shift left
    assign w_acc[NStates] = '0;
    for (genvar g = 0; g < NStates; g++) begin : g_cell
        ivhf_cell #(.MEIOSES(MEIOSES)) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_index    (IW'(g)),
            .i_allowed  (w_allow[g]),
            .i_q        (r_qd),
            .i_prob     (r_prob_q),
            .i_powers   (r_pow),
            .i_acc_next (w_acc[g+1]),
            .o_acc      (w_acc[g])
        );
    end

    // read data is registered after the address, so the index is registered with it
    always_ff @(posedge i_clk) begin
        r_prob_q <= r_prev[r_cnt[IW-1:0]];
        r_qd     <= r_cnt[IW-1:0];
    end

    // the emit cycle starts the next divide from the cell about to shift in
    assign w_num_acc = (r_state == S_EMIT) ? w_acc[1] : w_acc[0];

    ivhf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (w_div_go),
        .i_num  ({1'b0, w_num_acc, 15'd0} + {16'd0, 1'b0, r_total[39:1]}),
        .i_den  (r_total),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign w_prob = (r_total == '0) ? '0 :
                    (w_quot > 56'(OneQ15)) ? 16'(OneQ15) : w_quot[15:0];

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = i_item.first_locus ? S_SUM : S_POW;
            S_POW:  if (r_tk == 4'(MEIOSES + 1)) n_state = S_ACC;
            S_ACC:  if (r_cnt == (IW+1)'(NStates)) n_state = S_SUM;
            S_SUM:  if (r_cnt == (IW+1)'(NStates)) n_state = S_DIV;
            S_DIV:  if (w_div_done) n_state = S_EMIT;
            S_EMIT: n_state = (r_cnt == (IW+1)'(NStates - 1)) ? S_IDLE : S_DIV;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ctl = '0;
        w_div_go = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_ctl.clear = i_start && !i_item.first_locus;
                w_ctl.load_first = i_start && i_item.first_locus;
            end
            // at count zero there is no step: only the first prev value is loaded
            S_ACC:  w_ctl.step = (r_cnt != '0);
            S_SUM:  w_ctl.shift_out = 1'b0;
            S_DIV:  w_div_go = 1'b0;
            S_EMIT: w_ctl.shift_out = 1'b1;
            default: w_ctl = '0;
        endcase
        if (r_state == S_SUM && r_cnt == (IW+1)'(NStates)) w_div_go = 1'b1;
        if (r_state == S_EMIT && r_cnt != (IW+1)'(NStates - 1)) w_div_go = 1'b1;
    end

    // total walks the row through a mux, one cell per cycle
    function automatic logic [39:0] g_sum(input logic [IW-1:0] a);
        logic [39:0] v;
        v = '0;
        for (int i = 0; i < NStates; i++) begin
            if (IW'(i) == a) v = w_acc[i];
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    r_total <= '0;
                    if (i_start) begin
                        r_mask  <= i_item.allowed_mask;
                        r_r     <= (i_item.recomb_fraction > 15'(HalfQ15)) ?
                                   15'(HalfQ15) : i_item.recomb_fraction;
                    end
                end
                S_POW: r_cnt <= '0;
                S_ACC: r_cnt <= (n_state == S_SUM) ? '0 : r_cnt + 1'b1;
                S_SUM: begin
                    // total from a small address-walk over the cells
                    if (r_cnt != (IW+1)'(NStates)) begin
                        r_total <= r_total + g_sum(r_cnt[IW-1:0]);
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_cnt <= '0;
                    end
                end
                S_DIV: ;
                S_EMIT: begin
                    r_prev[r_cnt[IW-1:0]] <= w_prob;
                    o_valid <= 1'b1;
                    o_result.state_index <= 6'(r_cnt);
                    o_result.probability <= w_prob;
                    o_result.last_state  <= (r_cnt == (IW+1)'(NStates - 1));
                    r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("busy not raised");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy)) else $error("result while idle");
    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.probability <= 16'(OneQ15))) else $error("prob over one");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_state) |-> !o_busy) else $error("last not final");
`endif

endmodule
